// ----- hdl/u8u16_pkg.sv -----
`default_nettype none

package u8u16_pkg;

    // One UTF-8 source byte and its end-of-span flag.
    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_span;
    } t_in_item;

    // One UTF-16 result unit.
    typedef struct packed {
        logic [15:0] code_unit;
        logic        replaced;
        logic        run_last;
    } t_out_item;

    // Most units that one source byte can cause.
    localparam int unsigned C_MAX_UNITS = 4;

    localparam logic [15:0] C_REPL       = 16'hFFFD;
    localparam logic [15:0] C_HI_BASE    = 16'hD800;
    localparam logic [15:0] C_LO_BASE    = 16'hDC00;
    localparam logic [7:0]  C_LEAD_MIN   = 8'hC2;
    localparam logic [7:0]  C_LEAD_3B    = 8'hE0;
    localparam logic [7:0]  C_LEAD_4B    = 8'hF0;
    localparam logic [7:0]  C_LEAD_LIMIT = 8'hF5;
    localparam logic [15:0] C_MIN_3B     = 16'h0800;
    localparam logic [20:0] C_SUPP_BASE  = 21'h010000;
    localparam logic [20:0] C_CP_MAX     = 21'h10FFFF;

endpackage

`default_nettype wire

// ----- hdl/utf8_to_utf16_transcoder.sv -----
// Path: an accepted input beat goes into the input register, then its units into
// the result buffer that drives the output.
// Throughput: one byte per cycle while each byte gives at most one unit and the
// output is ready; a byte that gives more units (up to four) holds the next byte
// while the four-entry result buffer drains, one unit per cycle when not stalled.
// Reset: synchronous, active low; clears the valid flags and decoder state but r_held.
`default_nettype none

module utf8_to_utf16_transcoder (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_in_valid,
    output logic                       o_in_ready,
    input  wire u8u16_pkg::t_in_item   i_in_item,
    output logic                       o_out_valid,
    input  wire                        i_out_ready,
    output u8u16_pkg::t_out_item       o_out_item
);
    import u8u16_pkg::*;

    // Input register.
    logic      r_in_valid;
    t_in_item  r_in;

    // Decoder state.
    logic [7:0] r_lead;
    logic [7:0] r_held [2];
    logic [1:0] r_hcnt;
    logic       r_pend;
    logic       r_aterm;

    logic [7:0] n_lead;
    logic [1:0] n_hcnt;
    logic       n_pend;
    logic       n_aterm;
    logic       n_held_we;

    // Result buffer; entry 0 drives the output.
    t_out_item  r_buf [C_MAX_UNITS];
    logic [2:0] r_cnt;
    t_out_item  n_buf [C_MAX_UNITS];
    logic [2:0] n_cnt;

    logic go;
    logic out_take;

    logic [7:0] b;
    logic       eos;

    assign b   = r_in.in_byte;
    assign eos = r_in.end_of_span;

    // Handshakes: a buffered byte is processed once the buffer is empty or drains now.
    assign out_take    = o_out_valid && i_out_ready;
    assign go          = r_in_valid && ((r_cnt == 3'd0) || ((r_cnt == 3'd1) && i_out_ready));
    assign o_in_ready  = !r_in_valid || go;
    assign o_out_valid = (r_cnt != 3'd0);
    assign o_out_item  = r_buf[0];

    // Lead byte handling.
    logic        tl_emit;
    logic [15:0] tl_unit;
    logic        tl_repl;
    logic        tl_term;
    logic        tl_start;

    always_comb begin
        tl_emit  = 1'b1;
        tl_unit  = C_REPL;
        tl_repl  = 1'b1;
        tl_term  = 1'b0;
        tl_start = 1'b0;
        if (b == 8'h00) begin
            tl_unit = 16'h0000;
            tl_repl = 1'b0;
            tl_term = 1'b1;
        end else if (!b[7]) begin
            tl_unit = {8'h00, b};
            tl_repl = 1'b0;
        end else if ((b < C_LEAD_MIN) || (b >= C_LEAD_LIMIT)) begin
            tl_emit = 1'b1;
        end else if (eos) begin
            tl_emit = 1'b1;
        end else begin
            tl_emit  = 1'b0;
            tl_start = 1'b1;
        end
    end

    // Code point assembly and range checks for the completing byte.
    logic [1:0]  need;
    logic        complete;
    logic [10:0] cp2;
    logic [15:0] cp3;
    logic [20:0] cp4;
    logic [20:0] cpm;
    logic        dec_bad;
    logic        dec_pair;
    logic [15:0] dec_unit;
    logic [15:0] dec_hi;
    logic [15:0] dec_lo;

    always_comb begin
        if (r_lead < C_LEAD_3B) begin
            need = 2'd1;
        end else if (r_lead < C_LEAD_4B) begin
            need = 2'd2;
        end else begin
            need = 2'd3;
        end
        complete = ({1'b0, r_hcnt} + 3'd1) >= {1'b0, need};
        cp2 = {r_lead[4:0], b[5:0]};
        cp3 = {r_lead[3:0], r_held[0][5:0], b[5:0]};
        cp4 = {r_lead[2:0], r_held[0][5:0], r_held[1][5:0], b[5:0]};
        cpm = cp4 - C_SUPP_BASE;
        dec_hi = C_HI_BASE + {6'b0, cpm[19:10]};
        dec_lo = C_LO_BASE + {6'b0, cpm[9:0]};
        dec_pair = 1'b0;
        if (need == 2'd1) begin
            dec_bad  = (r_lead[4:1] == 4'b0000);
            dec_unit = {5'b0, cp2};
        end else if (need == 2'd2) begin
            dec_bad  = (cp3 < C_MIN_3B) || (cp3[15:11] == 5'b11011);
            dec_unit = cp3;
        end else begin
            dec_bad  = (cp4 < C_SUPP_BASE) || (cp4 > C_CP_MAX);
            dec_pair = 1'b1;
            dec_unit = dec_hi;
        end
    end

    // Next state and the list of units for this byte.
    logic [1:0]  fail_cnt;
    logic [1:0]  tail_cnt;
    logic [15:0] tail0_unit;
    logic        tail0_repl;
    logic [15:0] tail1_unit;

    always_comb begin
        n_lead     = r_lead;
        n_hcnt     = r_hcnt;
        n_pend     = r_pend;
        n_aterm    = r_aterm;
        n_held_we  = 1'b0;
        fail_cnt   = 2'd0;
        tail_cnt   = 2'd0;
        tail0_unit = tl_unit;
        tail0_repl = tl_repl;
        tail1_unit = dec_lo;
        if (!r_aterm) begin
            if (r_pend && (b[7:6] == 2'b10)) begin
                if (complete) begin
                    n_pend = 1'b0;
                    n_hcnt = 2'd0;
                    if (dec_bad) begin
                        tail_cnt   = 2'd1;
                        tail0_unit = C_REPL;
                        tail0_repl = 1'b1;
                    end else begin
                        tail_cnt   = dec_pair ? 2'd2 : 2'd1;
                        tail0_unit = dec_unit;
                        tail0_repl = 1'b0;
                    end
                end else begin
                    n_held_we = 1'b1;
                    n_hcnt    = r_hcnt + 2'd1;
                    if (eos) begin
                        // Truncated: the lead and every held byte, this one included.
                        fail_cnt = r_hcnt + 2'd2;
                    end
                end
            end else begin
                if (r_pend) begin
                    // Broken: a replacement for the lead and each held byte, then a fresh lead.
                    fail_cnt = r_hcnt + 2'd1;
                    n_pend   = 1'b0;
                    n_hcnt   = 2'd0;
                end
                tail_cnt = tl_emit ? 2'd1 : 2'd0;
                if (tl_term) begin
                    n_aterm = 1'b1;
                end
                if (tl_start) begin
                    n_lead = b;
                    n_hcnt = 2'd0;
                    n_pend = 1'b1;
                end
            end
        end
        if (eos) begin
            n_aterm = 1'b0;
            n_pend  = 1'b0;
            n_hcnt  = 2'd0;
        end
    end

    // Lay out replacements first, then the tail units.
    always_comb begin
        n_cnt = {1'b0, fail_cnt} + {1'b0, tail_cnt};
        for (int i = 0; i < C_MAX_UNITS; i++) begin
            if (3'(i) < {1'b0, fail_cnt}) begin
                n_buf[i].code_unit = C_REPL;
                n_buf[i].replaced  = 1'b1;
            end else if (3'(i) == {1'b0, fail_cnt}) begin
                n_buf[i].code_unit = tail0_unit;
                n_buf[i].replaced  = tail0_repl;
            end else begin
                n_buf[i].code_unit = tail1_unit;
                n_buf[i].replaced  = 1'b0;
            end
            n_buf[i].run_last = (3'(i) + 3'd1) == n_cnt;
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_cnt      <= 3'd0;
            r_lead     <= 8'h00;
            r_hcnt     <= 2'd0;
            r_pend     <= 1'b0;
            r_aterm    <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (go) begin
                r_cnt   <= n_cnt;
                r_lead  <= n_lead;
                r_hcnt  <= n_hcnt;
                r_pend  <= n_pend;
                r_aterm <= n_aterm;
            end else if (out_take) begin
                r_cnt <= r_cnt - 3'd1;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in <= i_in_item;
        end
        if (go && n_held_we) begin
            r_held[r_hcnt[0]] <= b;
        end
        if (go) begin
            for (int i = 0; i < C_MAX_UNITS; i++) begin
                r_buf[i] <= n_buf[i];
            end
        end else if (out_take) begin
            for (int i = 0; i < C_MAX_UNITS - 1; i++) begin
                r_buf[i] <= r_buf[i + 1];
            end
        end
    end

endmodule

`default_nettype wire

// ----- hdl/u8u16_checker.sv -----
`default_nettype none

module u8u16_checker (
    input wire                       i_clk,
    input wire                       i_rst_n,
    input wire                       i_in_ready,
    input wire                       i_out_valid,
    input wire                       i_out_ready,
    input wire u8u16_pkg::t_out_item i_out_item
);
    import u8u16_pkg::*;

    // A stalled result beat keeps its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_item))
        else $error("result beat changed while stalled");

    // Reset empties the result buffer.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    // Input back-pressure only arises while results are waiting.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> i_out_valid)
        else $error("input stalled with no pending result");

    // A replacement unit is always U+FFFD.
    a_repl_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_item.replaced |-> i_out_item.code_unit == C_REPL)
        else $error("replacement unit is not U+FFFD");

    // A high surrogate never closes a run, so its low half from the same byte follows.
    a_pair_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_out_item.code_unit[15:10] == 6'b110110) |-> !i_out_item.run_last)
        else $error("high surrogate closes a run");

endmodule

bind utf8_to_utf16_transcoder u8u16_checker u_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (o_in_ready),
    .i_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .i_out_item  (o_out_item)
);

`default_nettype wire

// ----- tb/sv/testbench.sv -----
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import u8u16_pkg::*;

    // Cycles to let pass after the last expected unit before the block is idle.
    localparam int DRAIN_CYCLES = 8;
    // Cycles without any accepted beat, while work is pending, before giving up.
    localparam int STALL_LIMIT = 2000;
    // Length of the long output hold-off used to fill the block.
    localparam int HOLD_OFF_LEN = 200;
    localparam int MAX_REPORTS = 10;

    localparam logic [7:0]  ASCII_LIMIT  = 8'h80;
    localparam logic [7:0]  CONT_FIRST   = 8'h80;
    localparam logic [7:0]  CONT_LAST    = 8'hBF;
    localparam logic [20:0] MIN_2B       = 21'h000080;
    localparam logic [20:0] SURR_FIRST   = 21'h00D800;
    localparam logic [20:0] SURR_LAST    = 21'h00DFFF;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_in_valid = 1'b0;
    t_in_item   i_in_item = '0;
    logic       i_out_ready = 1'b0;
    logic       o_in_ready;
    logic       o_out_valid;
    t_out_item  o_out_item;

    utf8_to_utf16_transcoder DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Traffic shaping knobs: idle and stall chances in percent, and hold-off cycles left.
    int send_idle_pct = 0;
    int stall_pct = 0;
    int hold_off_left = 0;

    int n_errors = 0;
    int idle_cycles = 0;

    // Decoder state mirrored by the predictor.
    logic [7:0] dec_lead = '0;
    logic [7:0] dec_cont [2];
    logic [1:0] dec_held = '0;
    logic       dec_pending = 1'b0;
    logic       dec_after_nul = 1'b0;

    t_out_item  step_units[$];
    t_out_item  expected_units[$];
    logic [7:0] span_bytes[$];

    // Predictor helpers: each appends to the units of the current byte.
    function automatic void push_unit(input logic [15:0] code, input logic repl);
        t_out_item u;
        u.code_unit = code;
        u.replaced  = repl;
        u.run_last  = 1'b0;
        step_units.push_back(u);
    endfunction

    // A broken sequence gives one replacement for the lead and one per held byte.
    function automatic void flush_failed();
        push_unit(C_REPL, 1'b1);
        for (int k = 0; k < dec_held && k < 2; k++) begin
            push_unit(C_REPL, 1'b1);
        end
        dec_pending = 1'b0;
        dec_held = '0;
    endfunction

    function automatic void take_lead(input logic [7:0] b, input logic eos);
        if (b == 8'h00) begin
            push_unit(16'h0000, 1'b0);
            dec_after_nul = 1'b1;
        end else if (b < ASCII_LIMIT) begin
            push_unit({8'h00, b}, 1'b0);
        end else if (b < C_LEAD_MIN || b >= C_LEAD_LIMIT) begin
            push_unit(C_REPL, 1'b1);
        end else if (eos) begin
            push_unit(C_REPL, 1'b1);
        end else begin
            dec_lead = b;
            dec_held = '0;
            dec_pending = 1'b1;
        end
    endfunction

    // Works out the units that one accepted source byte causes.
    function automatic void predict_units(input t_in_item beat);
        logic [7:0]  b;
        logic        eos;
        int          need;
        logic [20:0] cp;
        logic [20:0] off;
        logic        bad;
        b = beat.in_byte;
        eos = beat.end_of_span;
        step_units.delete();
        if (dec_after_nul) begin
            // Rest of the span after a NUL is dropped.
        end else if (dec_pending) begin
            need = (dec_lead < C_LEAD_3B) ? 1 : ((dec_lead < C_LEAD_4B) ? 2 : 3);
            if (b[7:6] == 2'b10) begin
                if (dec_held + 1 >= need) begin
                    if (dec_lead < C_LEAD_3B) begin
                        cp = {10'b0, dec_lead[4:0], b[5:0]};
                        bad = cp < MIN_2B;
                    end else if (dec_lead < C_LEAD_4B) begin
                        cp = {5'b0, dec_lead[3:0], dec_cont[0][5:0], b[5:0]};
                        bad = cp < {5'b0, C_MIN_3B} || (cp >= SURR_FIRST && cp <= SURR_LAST);
                    end else begin
                        cp = {dec_lead[2:0], dec_cont[0][5:0], dec_cont[1][5:0], b[5:0]};
                        bad = cp < C_SUPP_BASE || cp > C_CP_MAX;
                    end
                    if (bad) begin
                        push_unit(C_REPL, 1'b1);
                    end else if (cp < C_SUPP_BASE) begin
                        push_unit(cp[15:0], 1'b0);
                    end else begin
                        off = cp - C_SUPP_BASE;
                        push_unit(C_HI_BASE + {6'b0, off[19:10]}, 1'b0);
                        push_unit(C_LO_BASE + {6'b0, off[9:0]}, 1'b0);
                    end
                    dec_pending = 1'b0;
                    dec_held = '0;
                end else begin
                    if (dec_held < 2) dec_cont[dec_held[0]] = b;
                    dec_held = dec_held + 2'd1;
                    if (eos) flush_failed();
                end
            end else begin
                flush_failed();
                take_lead(b, eos);
            end
        end else begin
            take_lead(b, eos);
        end

        if (eos) begin
            dec_after_nul = 1'b0;
            dec_pending = 1'b0;
            dec_held = '0;
        end
        if (step_units.size() > 0) step_units[step_units.size() - 1].run_last = 1'b1;
        foreach (step_units[k]) expected_units.push_back(step_units[k]);
    endfunction

    // Checks each result beat against the oldest expected unit, then predicts
    // the units of the source beat accepted at the same edge.
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (expected_units.size() == 0) begin
                    if (n_errors < MAX_REPORTS)
                        $display("unexpected result beat: unit %h replaced %b last %b",
                                 o_out_item.code_unit, o_out_item.replaced,
                                 o_out_item.run_last);
                    n_errors++;
                end else begin
                    want = expected_units.pop_front();
                    if (o_out_item.code_unit !== want.code_unit ||
                        o_out_item.replaced !== want.replaced ||
                        o_out_item.run_last !== want.run_last) begin
                        if (n_errors < MAX_REPORTS)
                            $display("mismatch: unit %h replaced %b last %b, expected %h %b %b",
                                     o_out_item.code_unit, o_out_item.replaced,
                                     o_out_item.run_last, want.code_unit, want.replaced,
                                     want.run_last);
                        n_errors++;
                    end
                end
            end
            if (i_in_valid && o_in_ready) predict_units(i_in_item);
        end
    end

    // Output ready: a long hold-off when one is requested, random stalls otherwise.
    always @(posedge i_clk) begin
        if (hold_off_left > 0) begin
            hold_off_left = hold_off_left - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Watchdog: counts cycles with pending work in which no beat moves.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (!i_in_valid && expected_units.size() == 0)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles = idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Offers one source beat after a random gap and waits until it is taken.
    task automatic send_beat(input logic [7:0] b, input logic eos);
        t_in_item beat;
        beat.in_byte = b;
        beat.end_of_span = eos;
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item <= beat;
        do @(posedge i_clk); while (!(i_in_valid && o_in_ready));
    endtask

    // Sends the bytes in span_bytes, flagging the last one as the span end.
    task automatic send_span();
        foreach (span_bytes[k]) send_beat(span_bytes[k], k == span_bytes.size() - 1);
    endtask

    // Stops sending until every expected unit has arrived and the block is quiet.
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_units.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic add_continuations(input int count);
        logic [7:0] b;
        repeat (count) begin
            b = 8'($urandom_range(CONT_FIRST, CONT_LAST));
            span_bytes.push_back(b);
        end
    endtask

    // Builds a span of random characters; most are well formed, some are
    // invalid leads, broken or cut-off sequences, NULs and raw noise.
    task automatic build_random_span();
        int         n_chars;
        int         r;
        int         need;
        logic [7:0] b;
        logic       cut;
        span_bytes.delete();
        cut = 1'b0;
        n_chars = $urandom_range(1, 6);
        for (int k = 0; k < n_chars && !cut; k++) begin
            r = $urandom_range(99);
            if (r < 14) begin
                b = 8'($urandom_range(1, 127));
                span_bytes.push_back(b);
            end else if (r < 34) begin
                b = 8'($urandom_range(C_LEAD_MIN, C_LEAD_3B - 1));
                span_bytes.push_back(b);
                add_continuations(1);
            end else if (r < 54) begin
                b = 8'($urandom_range(C_LEAD_3B, C_LEAD_4B - 1));
                span_bytes.push_back(b);
                add_continuations(2);
            end else if (r < 72) begin
                b = 8'($urandom_range(C_LEAD_4B, C_LEAD_LIMIT - 1));
                span_bytes.push_back(b);
                add_continuations(3);
            end else if (r < 80) begin
                if ($urandom_range(1))
                    b = 8'($urandom_range(CONT_FIRST, C_LEAD_MIN - 1));
                else
                    b = 8'($urandom_range(C_LEAD_LIMIT, 255));
                span_bytes.push_back(b);
            end else if (r < 92) begin
                // Sequence that stops short: either the span ends inside it or
                // a byte that is not a continuation breaks it.
                b = 8'($urandom_range(C_LEAD_MIN, C_LEAD_LIMIT - 1));
                need = (b < C_LEAD_3B) ? 1 : ((b < C_LEAD_4B) ? 2 : 3);
                span_bytes.push_back(b);
                add_continuations($urandom_range(0, need - 1));
                if ($urandom_range(1)) begin
                    cut = 1'b1;
                end else begin
                    do b = 8'($urandom_range(255)); while (b[7:6] == 2'b10);
                    span_bytes.push_back(b);
                end
            end else if (r < 96) begin
                span_bytes.push_back(8'h00);
            end else begin
                b = 8'($urandom_range(255));
                span_bytes.push_back(b);
            end
        end
    endtask

    // Extremes of the ranges and each kind of malformed input, back to back.
    task automatic test_directed_cases();
        send_idle_pct = 0;
        stall_pct = 0;
        // ASCII, smallest two-byte, well-formed EF BF BD, encoded surrogate,
        // overlong three-byte, largest code point, above the limit, invalid
        // lead F5-FF, wrong continuation on a four-byte lead, truncation.
        span_bytes = '{8'h41, 8'hC2, 8'h80, 8'hEF, 8'hBF, 8'hBD, 8'hED, 8'hA0, 8'h80,
                       8'hE0, 8'h9F, 8'hBF, 8'hF4, 8'h8F, 8'hBF, 8'hBF,
                       8'hF4, 8'h90, 8'h80, 8'h80, 8'hFF,
                       8'hF0, 8'h90, 8'h80, 8'h7F, 8'hE2, 8'h82};
        send_span();
        // Invalid lead 80-C1, then a lead that is the last byte of its span.
        span_bytes = '{8'hC1, 8'hC2};
        send_span();
        // NUL: the bytes after it are ignored up to the span end.
        span_bytes = '{8'h00, 8'hF0, 8'h7F};
        send_span();
        wait_drained();
    endtask

    // The sender pauses inside a sequence until the block has gone quiet.
    task automatic test_pause_mid_sequence();
        send_idle_pct = 0;
        stall_pct = 0;
        send_beat(8'hE2, 1'b0);
        wait_drained();
        send_beat(8'h82, 1'b0);
        wait_drained();
        send_beat(8'hAC, 1'b1);
        wait_drained();
    endtask

    task automatic test_random_traffic(input int n_items, input int idle_pct,
                                       input int stall_level);
        int   sent;
        logic nul_seen;
        send_idle_pct = idle_pct;
        stall_pct = stall_level;
        sent = 0;
        while (sent < n_items) begin
            build_random_span();
            // Bytes dropped after a NUL do not count.
            nul_seen = 1'b0;
            foreach (span_bytes[k]) begin
                if (!nul_seen) sent++;
                if (span_bytes[k] == 8'h00) nul_seen = 1'b1;
            end
            send_span();
        end
        wait_drained();
    endtask

    // The output is held off for a long stretch while source beats keep
    // coming, so the result buffer fills and the input stalls.
    task automatic test_output_hold_off();
        send_idle_pct = 0;
        stall_pct = 0;
        hold_off_left = HOLD_OFF_LEN;
        test_random_traffic(30, 0, 0);
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_cases();
        test_pause_mid_sequence();
        test_random_traffic(60, 0, 0);
        test_random_traffic(60, 63, 0);
        test_random_traffic(60, 0, 63);
        test_random_traffic(60, 31, 31);
        test_output_hold_off();

        if (expected_units.size() != 0) begin
            $display("%0d expected units never arrived", expected_units.size());
            n_errors += expected_units.size();
        end
        if (n_errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
